>>> rtl/sbe_pkg.sv
// Package: shared constants, opcodes, tags and error codes for the bytecode executor.
`default_nettype none
package sbe_pkg;
  localparam int unsigned StackDepth  = 64;
  localparam int unsigned GlobalSlots = 256;
  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned SpW   = $clog2(StackDepth) + 1;
  localparam int unsigned SaW   = $clog2(StackDepth);
  localparam int unsigned GaW   = (GlobalSlots > 1) ? $clog2(GlobalSlots) : 1;
  localparam int unsigned EntW  = ValueWidth + 2;

  typedef enum logic [4:0] {
    OP_CONST = 5'd0, OP_TRUE = 5'd1, OP_BFALSE = 5'd2, OP_ADD = 5'd3, OP_SUB = 5'd4,
    OP_MUL = 5'd5, OP_DIV = 5'd6, OP_EQ = 5'd7, OP_LESS = 5'd8, OP_JUMP = 5'd9,
    OP_JIF = 5'd10, OP_LOOP = 5'd11, OP_SHOW = 5'd12, OP_READ = 5'd13,
    OP_DEFG = 5'd14, OP_GETG = 5'd15, OP_SETG = 5'd16, OP_RET = 5'd17
  } op_e;

  localparam logic [1:0] TagNone = 2'd0;
  localparam logic [1:0] TagInt  = 2'd1;
  localparam logic [1:0] TagBool = 2'd2;

  localparam logic [2:0] ErrNone   = 3'd0;
  localparam logic [2:0] ErrOpcode = 3'd1;
  localparam logic [2:0] ErrUnder  = 3'd2;
  localparam logic [2:0] ErrOver   = 3'd3;
  localparam logic [2:0] ErrDivz   = 3'd4;
endpackage
`default_nettype wire

>>> rtl/sbe_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module sbe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

>>> rtl/sbe_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module sbe_div import sbe_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [ValueWidth-1:0] a_i,
  input  wire logic [ValueWidth-1:0] b_i,
  output logic                       done_o,
  output logic      [ValueWidth-1:0] q_o
);
  localparam int unsigned CntW = $clog2(ValueWidth + 1);
  logic [ValueWidth-1:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic neg_q, neg_d, busy_q, busy_d;
  logic [ValueWidth:0] trial;
  logic [ValueWidth-1:0] ma, mb;

  always_comb begin
    ma = a_i[ValueWidth-1] ? (~a_i + 1'b1) : a_i;
    mb = b_i[ValueWidth-1] ? (~b_i + 1'b1) : b_i;
    rem_d = rem_q; quo_d = quo_q; dvs_d = dvs_q; cnt_d = cnt_q;
    neg_d = neg_q; busy_d = busy_q;
    trial = {rem_q, quo_q[ValueWidth-1]} - {1'b0, dvs_q};
    done_o = 1'b0;
    if (start_i && !busy_q) begin
      rem_d = '0; quo_d = ma; dvs_d = mb; neg_d = a_i[ValueWidth-1] ^ b_i[ValueWidth-1];
      cnt_d = CntW'(ValueWidth); busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        done_o = 1'b1; busy_d = 1'b0;
      end else begin
        if (!trial[ValueWidth]) begin
          rem_d = trial[ValueWidth-1:0];
          quo_d = {quo_q[ValueWidth-2:0], 1'b1};
        end else begin
          rem_d = {rem_q[ValueWidth-2:0], quo_q[ValueWidth-1]};
          quo_d = {quo_q[ValueWidth-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
      end
    end
  end
  assign q_o = neg_q ? (~quo_q + 1'b1) : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; dvs_q <= dvs_d; neg_q <= neg_d;
  end
endmodule
`default_nettype wire

>>> rtl/stack_bytecode_executor_top.sv
// Top level: tagged-value stack bytecode executor built around stack and global RAMs.
// Usage: one decoded instruction enters on the in channel (in_valid_i / in_stall_o)
// and yields exactly one result on the out channel (out_valid_o / out_stall_i).
// Each instruction is fetched into a register, the two top stack entries are read
// from the stack RAM (one per cycle) together with the addressed global slot,
// then the result is computed and written back. The work runs through the states
// S_RD1, S_RD2 and S_EXE, and the result is registered; a new item is accepted
// only back in S_IDLE. The single stack RAM read port puts the two reads in turn.
// Divide waits in S_DIV for the bit-serial divider before writing back.
// Only one instruction is in flight; in_stall_o is high from accept until the block
// is idle again, and also while a finished result waits under out_stall_i.
// Reset: the PC, stack pointer, halt flag and error clear at once; the global
// store is then cleared by a sweep over all GlobalSlots slots during which no item is
// accepted. The stack RAM is not cleared. While out_stall_i is high the result
// holds and the block stops after finishing the current instruction.
// Once halted, every item returns the held PC, halted and error, with no print,
// in the cycle after accept.
`default_nettype none
module stack_bytecode_executor_top import sbe_pkg::*; (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [4:0]                   func_i,
  input  wire logic [7:0]                   slot_index_i,
  input  wire logic [15:0]                  jump_distance_i,
  input  wire logic signed [31:0]           operand_value_i,
  input  wire logic [1:0]                   operand_tag_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [15:0]                       next_ip_o,
  output logic                              print_valid_o,
  output logic signed [31:0]                print_value_o,
  output logic [1:0]                        print_tag_o,
  output logic                              halted_o,
  output logic [2:0]                        error_code_o
);
  typedef enum logic [5:0] {
    S_CLR  = 6'b000001, S_IDLE = 6'b000010, S_RD1 = 6'b000100,
    S_RD2  = 6'b001000, S_EXE  = 6'b010000, S_DIV = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [15:0] pc_q, pc_d;
  logic [SpW-1:0] sp_q, sp_d;
  logic halt_q, halt_d;
  logic [2:0] err_q, err_d;
  logic [GaW-1:0] clr_q, clr_d;

  logic [4:0] fn_q; logic [GaW-1:0] slot_q; logic [15:0] dist_q;
  logic [ValueWidth-1:0] opv_q; logic [1:0] otag_q;
  logic [EntW-1:0] top_q, top_d;  // top of stack entry, captured after first read

  logic ov_q, ov_d;
  logic [15:0] rip_q, rip_d; logic rpv_q, rpv_d; logic [31:0] rpval_q, rpval_d;
  logic [1:0] rptag_q, rptag_d; logic rhalt_q, rhalt_d; logic [2:0] rerr_q, rerr_d;

  logic s_we; logic [SaW-1:0] s_wa, s_ra; logic [EntW-1:0] s_wd, s_rd;
  logic g_we; logic [GaW-1:0] g_wa; logic [EntW-1:0] g_wd, g_rd;
  logic div_start, div_done; logic [ValueWidth-1:0] div_q;

  sbe_ram #(.Width(EntW), .Depth(StackDepth)) u_stack (
    .clk_i, .we_i(s_we), .waddr_i(s_wa), .wdata_i(s_wd), .raddr_i(s_ra), .rdata_o(s_rd));
  sbe_ram #(.Width(EntW), .Depth(GlobalSlots)) u_glob (
    .clk_i, .we_i(g_we), .waddr_i(g_wa), .wdata_i(g_wd), .raddr_i(slot_q), .rdata_o(g_rd));
  sbe_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .a_i(s_rd[ValueWidth-1:0]),
    .b_i(top_q[ValueWidth-1:0]), .done_o(div_done), .q_o(div_q));

  wire accept = in_valid_i && !in_stall_o;
  wire out_take = ov_q && !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || (ov_q && out_stall_i);

  logic [1:0] b_tag, a_tag; logic [ValueWidth-1:0] b_v, a_v;
  logic [2*ValueWidth-1:0] prod;
  logic ints;
  assign b_tag = top_q[EntW-1 -: 2];
  assign b_v = top_q[ValueWidth-1:0];
  assign a_tag = s_rd[EntW-1 -: 2];
  assign a_v = s_rd[ValueWidth-1:0];
  assign ints = (b_tag == TagInt) && (a_tag == TagInt);
  assign prod = a_v * b_v;

  always_comb begin
    logic [15:0] nxt; logic [2:0] e; logic push; logic [EntW-1:0] pe;
    logic [SpW-1:0] nsp; logic fin;
    state_d = state_q; pc_d = pc_q; sp_d = sp_q; halt_d = halt_q; err_d = err_q;
    clr_d = clr_q; top_d = top_q; ov_d = ov_q && !out_take;
    rip_d = rip_q; rpv_d = rpv_q; rpval_d = rpval_q; rptag_d = rptag_q;
    rhalt_d = rhalt_q; rerr_d = rerr_q;
    s_we = 1'b0; s_wa = sp_q[SaW-1:0]; s_wd = '0; s_ra = SaW'(sp_q - 1'b1);
    g_we = 1'b0; g_wa = slot_q; g_wd = '0; div_start = 1'b0;
    nxt = pc_q; e = ErrNone; push = 1'b0; pe = '0; nsp = sp_q; fin = 1'b0;
    case (state_q)
      S_CLR: begin
        g_we = 1'b1; g_wa = clr_q; g_wd = '0; clr_d = clr_q + 1'b1;
        if (clr_q == GaW'(GlobalSlots - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (halt_q) begin
            ov_d = 1'b1; rip_d = pc_q; rpv_d = 1'b0; rpval_d = '0; rptag_d = TagNone;
            rhalt_d = 1'b1; rerr_d = err_q;
          end else state_d = S_RD1;
        end
      end
      S_RD1: begin  // s_rd holds entry sp-1
        top_d = s_rd; s_ra = SaW'(sp_q - 2'd2); state_d = S_RD2;
      end
      S_RD2: begin  // s_rd holds entry sp-2; keep it for the execute cycle
        s_ra = SaW'(sp_q - 2'd2); state_d = S_EXE;
      end
      S_DIV: begin
        if (div_done) begin
          s_we = 1'b1; s_wa = SaW'(sp_q - 2'd2); s_wd = {TagInt, div_q};
          sp_d = sp_q - 1'b1; pc_d = pc_q + 1'b1; fin = 1'b1; nxt = pc_q + 1'b1;
          state_d = S_IDLE;
        end
      end
      S_EXE: begin  // top_q = entry sp-1, s_rd = entry sp-2, g_rd = slot
        fin = 1'b1;
        case (fn_q)
          OP_CONST, OP_READ, OP_TRUE, OP_BFALSE, OP_GETG: begin
            if (sp_q >= SpW'(StackDepth)) e = ErrOver;
            else begin
              push = 1'b1;
              if (fn_q == OP_TRUE) pe = {TagBool, ValueWidth'(1)};
              else if (fn_q == OP_BFALSE) pe = {TagBool, {ValueWidth{1'b0}}};
              else if (fn_q == OP_GETG) pe = g_rd;
              else pe = {otag_q, opv_q};
              nxt = pc_q + ((fn_q == OP_CONST || fn_q == OP_GETG) ? 16'd2 : 16'd1);
            end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_LESS: begin
            if (sp_q < SpW'(2)) e = ErrUnder;
            else if (ints && fn_q == OP_DIV && b_v == '0) e = ErrDivz;
            else if (ints && fn_q == OP_DIV) begin
              div_start = 1'b1; fin = 1'b0; state_d = S_DIV;
            end else begin
              nxt = pc_q + 16'd1; nsp = sp_q - 2'd2;
              if (ints) begin
                push = 1'b1;
                case (fn_q)
                  OP_ADD:  pe = {TagInt, a_v + b_v};
                  OP_SUB:  pe = {TagInt, a_v - b_v};
                  OP_MUL:  pe = {TagInt, prod[ValueWidth-1:0]};
                  OP_EQ:   pe = {TagBool, ValueWidth'(a_v == b_v)};
                  default: pe = {TagBool, ValueWidth'($signed(a_v) < $signed(b_v))};
                endcase
              end
            end
          end
          OP_JUMP: nxt = pc_q + 16'd3 + dist_q;
          OP_LOOP: nxt = pc_q + 16'd3 - dist_q;
          OP_JIF: begin
            if (sp_q < SpW'(1)) e = ErrUnder;
            else begin
              nsp = sp_q - 1'b1; nxt = pc_q + 16'd3;
              if ((b_tag == TagBool || b_tag == TagInt) && b_v == '0) nxt = nxt + dist_q;
            end
          end
          OP_SHOW: begin
            if (sp_q < SpW'(1)) e = ErrUnder;
            else begin
              nsp = sp_q - 1'b1; nxt = pc_q + 16'd1;
            end
          end
          OP_DEFG, OP_SETG: begin
            if (sp_q < SpW'(1)) e = ErrUnder;
            else begin
              g_we = 1'b1; g_wd = top_q; nxt = pc_q + 16'd2;
              if (fn_q == OP_DEFG) nsp = sp_q - 1'b1;
            end
          end
          OP_RET: begin
            nxt = pc_q + 16'd1; halt_d = 1'b1;
          end
          default: e = ErrOpcode;
        endcase
        if (state_d != S_DIV) state_d = S_IDLE;
        if (e != ErrNone) begin
          g_we = 1'b0; push = 1'b0; nsp = sp_q; nxt = pc_q; halt_d = 1'b1; err_d = e;
        end
        if (push) begin
          s_we = 1'b1; s_wa = nsp[SaW-1:0]; s_wd = pe; nsp = nsp + 1'b1;
        end
        if (fin) begin
          sp_d = nsp; pc_d = nxt;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (fin) begin
      ov_d = 1'b1; rip_d = nxt; rhalt_d = halt_d; rerr_d = err_d;
      rpv_d = (state_q == S_EXE) && fn_q == OP_SHOW && e == ErrNone;
      rptag_d = rpv_d ? b_tag : TagNone;
      rpval_d = (rpv_d && b_tag != TagNone) ? b_v : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR; pc_q <= '0; sp_q <= '0; halt_q <= 1'b0; err_q <= ErrNone;
      clr_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; pc_q <= pc_d; sp_q <= sp_d; halt_q <= halt_d; err_q <= err_d;
      clr_q <= clr_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fn_q <= func_i; slot_q <= GaW'(slot_index_i % GlobalSlots); dist_q <= jump_distance_i;
      otag_q <= (operand_tag_i == TagInt || operand_tag_i == TagBool) ? operand_tag_i : TagNone;
      if (operand_tag_i == TagInt) opv_q <= ValueWidth'(operand_value_i);
      else if (operand_tag_i == TagBool) opv_q <= ValueWidth'(operand_value_i != 0);
      else opv_q <= '0;
    end
    top_q <= top_d;
    rip_q <= rip_d; rpv_q <= rpv_d; rpval_q <= rpval_d; rptag_q <= rptag_d;
    rhalt_q <= rhalt_d; rerr_q <= rerr_d;
  end

  assign out_valid_o = ov_q;
  assign next_ip_o = rip_q;
  assign print_valid_o = rpv_q;
  assign print_value_o = rpval_q;
  assign print_tag_o = rptag_q;
  assign halted_o = rhalt_q;
  assign error_code_o = rerr_q;
endmodule
`default_nettype wire
